// ----- hdl/fixed_block_free_list_allocator_unit_defines.svh -----
// Assertion macros for the checker file of the allocator.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FBFL_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbfl same-cycle check failed");

// Next-cycle implication.
`define FBFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbfl next-cycle check failed");

`endif

// ----- hdl/fbfl_pkg.sv -----
package fbfl_pkg;

    // Default pool depth.
    localparam int MAX_BUCKETS_DEF = 256;

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int BYTES_W  = 16;
    localparam int OFFSET_W = 24;

    // Register port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register select, taken from the word address bit.
    localparam logic REG_SEL_COUNT = 1'b0;
    localparam logic REG_SEL_BYTES = 1'b1;

    // Reset values and limits.
    localparam logic [COUNT_W-1:0] BUCKET_COUNT_RST = 9'd256;
    localparam logic [BYTES_W-1:0] BUCKET_BYTES_RST = 16'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 9'd511;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bucket_count;
        logic [BYTES_W-1:0] bucket_bytes;
    } cfg_t;

    typedef struct packed {
        logic                done;
        logic                ok;
        logic [INDEX_W-1:0]  granted_index;
        logic [OFFSET_W-1:0] byte_offset;
        logic [COUNT_W-1:0]  in_use;
    } result_t;

endpackage

// ----- hdl/fbfl_link_mem.sv -----
module fbfl_link_mem #(
    parameter int DEPTH  = fbfl_pkg::MAX_BUCKETS_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] link_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= link_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/fbfl_cfg_regs.sv -----
module fbfl_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbfl_pkg::ADDR_W-1:0]   paddr,
    input  logic [fbfl_pkg::DATA_W-1:0]   pwdata,
    output logic [fbfl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output fbfl_pkg::cfg_t                cfg
);

    fbfl_pkg::cfg_t cfg_reg;
    fbfl_pkg::cfg_t cfg_next;
    logic           wr_strobe;

    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite;

    // Register writes, decoded on the word address bit.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_strobe)
        begin
            case (paddr[2])
                fbfl_pkg::REG_SEL_COUNT:
                    cfg_next.bucket_count = pwdata[fbfl_pkg::COUNT_W-1:0];
                fbfl_pkg::REG_SEL_BYTES:
                    cfg_next.bucket_bytes = pwdata[fbfl_pkg::BYTES_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bucket_count <= fbfl_pkg::BUCKET_COUNT_RST;
            cfg_reg.bucket_bytes <= fbfl_pkg::BUCKET_BYTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (paddr[2])
            fbfl_pkg::REG_SEL_COUNT:
                prdata = fbfl_pkg::DATA_W'(cfg_reg.bucket_count);
            fbfl_pkg::REG_SEL_BYTES:
                prdata = fbfl_pkg::DATA_W'(cfg_reg.bucket_bytes);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/fbfl_ctrl.sv -----
module fbfl_ctrl #(
    parameter int MAX_BUCKETS = fbfl_pkg::MAX_BUCKETS_DEF,
    parameter int IDX_W       = $clog2(MAX_BUCKETS),
    parameter int LINK_W      = $clog2(MAX_BUCKETS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fbfl_pkg::CMD_W-1:0]    cmd,
    input  logic [fbfl_pkg::INDEX_W-1:0]  bucket_index,
    input  fbfl_pkg::cfg_t                cfg,
    output fbfl_pkg::result_t             result,
    output logic                          mem_wr_en,
    output logic [IDX_W-1:0]              mem_wr_addr,
    output logic [LINK_W-1:0]             mem_wr_data,
    output logic [IDX_W-1:0]              mem_rd_addr,
    input  logic [LINK_W-1:0]             mem_rd_data
);

    localparam int CMP_W   = (LINK_W > fbfl_pkg::COUNT_W) ? LINK_W : fbfl_pkg::COUNT_W;
    localparam int PROD_W  = IDX_W + fbfl_pkg::BYTES_W;
    localparam int PRODX_W = (PROD_W > fbfl_pkg::OFFSET_W) ? PROD_W : fbfl_pkg::OFFSET_W;
    localparam int RESET_N = (int'(fbfl_pkg::BUCKET_COUNT_RST) > MAX_BUCKETS) ?
                             MAX_BUCKETS : int'(fbfl_pkg::BUCKET_COUNT_RST);
    localparam logic [LINK_W-1:0] LINK_END    = LINK_W'(MAX_BUCKETS);
    localparam logic [LINK_W-1:0] RESET_LIMIT = LINK_W'(RESET_N);

    fbfl_pkg::state_t  state_reg,     state_next;
    logic [LINK_W-1:0] head_reg,      head_next;
    logic [fbfl_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [LINK_W-1:0] sweep_idx_reg, sweep_idx_next;
    logic [LINK_W-1:0] sweep_lim_reg, sweep_lim_next;
    logic              report_reg,    report_next;
    fbfl_pkg::result_t res_reg,       res_next;

    logic [CMP_W-1:0]   count_ext;
    logic [CMP_W-1:0]   max_ext;
    logic [CMP_W-1:0]   eff_cmp;
    logic [LINK_W-1:0]  eff_count;
    logic [CMP_W-1:0]   index_ext;
    logic [CMP_W-1:0]   head_ext;
    logic               index_ok;
    logic               head_valid;
    logic               accept;
    logic [PROD_W-1:0]  prod;
    logic [PRODX_W-1:0] prod_ext;
    logic [LINK_W-1:0]  sweep_idx_inc;
    logic [fbfl_pkg::COUNT_W-1:0] count_inc;
    logic [fbfl_pkg::COUNT_W-1:0] count_dec;

    // Effective bucket count, clamped to the pool depth.
    assign count_ext = CMP_W'(cfg.bucket_count);
    assign max_ext   = CMP_W'(MAX_BUCKETS);
    assign eff_cmp   = (count_ext > max_ext) ? max_ext : count_ext;
    assign eff_count = eff_cmp[LINK_W-1:0];

    assign index_ext  = CMP_W'(bucket_index);
    assign index_ok   = index_ext < eff_cmp;
    assign head_ext   = CMP_W'(head_reg);
    assign head_valid = head_reg < LINK_END;

    assign busy   = state_reg != fbfl_pkg::ST_IDLE;
    assign accept = start && (state_reg == fbfl_pkg::ST_IDLE);

    // Byte offset of the head bucket; registered into the result.
    assign prod     = PROD_W'(head_reg[IDX_W-1:0]) * PROD_W'(cfg.bucket_bytes);
    assign prod_ext = PRODX_W'(prod);

    // Saturating count steps.
    assign count_inc = (count_reg == fbfl_pkg::COUNT_MAX) ? count_reg :
                       count_reg + fbfl_pkg::COUNT_W'(1);
    assign count_dec = (count_reg == '0) ? count_reg : count_reg - fbfl_pkg::COUNT_W'(1);

    assign sweep_idx_inc = sweep_idx_reg + LINK_W'(1);

    // The link memory is always read at the head; the data is used in the following cycle.
    assign mem_rd_addr = head_reg[IDX_W-1:0];

    // Next state, results and link-memory writes.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        sweep_idx_next = sweep_idx_reg;
        sweep_lim_next = sweep_lim_reg;
        report_next    = report_reg;
        res_next       = res_reg;
        res_next.done  = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = sweep_idx_reg[IDX_W-1:0];
        mem_wr_data    = sweep_idx_inc;

        case (state_reg)
            fbfl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.done          = 1'b1;
                    res_next.ok            = 1'b0;
                    res_next.granted_index = '0;
                    res_next.byte_offset   = '0;
                    res_next.in_use        = count_reg;
                    case (fbfl_pkg::cmd_t'(cmd))
                        fbfl_pkg::CMD_ALLOC:
                        begin
                            // An empty list answers at once; otherwise wait for the link.
                            if (head_valid)
                            begin
                                res_next.done = 1'b0;
                                state_next    = fbfl_pkg::ST_ALLOC;
                            end
                        end
                        fbfl_pkg::CMD_FREE:
                        begin
                            // Push the bucket onto the head of the list.
                            if (index_ok)
                            begin
                                mem_wr_en       = 1'b1;
                                mem_wr_addr     = index_ext[IDX_W-1:0];
                                mem_wr_data     = head_reg;
                                head_next       = index_ext[LINK_W-1:0];
                                count_next      = count_dec;
                                res_next.ok     = 1'b1;
                                res_next.in_use = count_dec;
                            end
                        end
                        fbfl_pkg::CMD_CLEAR:
                        begin
                            res_next.done  = 1'b0;
                            state_next     = fbfl_pkg::ST_SWEEP;
                            sweep_idx_next = '0;
                            sweep_lim_next = eff_count;
                            report_next    = 1'b1;
                        end
                        default:
                        begin
                            res_next.ok = 1'b0;
                        end
                    endcase
                end
            end

            fbfl_pkg::ST_ALLOC:
            begin
                // Pop: the link read at the accept edge becomes the new head.
                head_next              = mem_rd_data;
                count_next             = count_inc;
                res_next.done          = 1'b1;
                res_next.ok            = 1'b1;
                res_next.granted_index = head_ext[fbfl_pkg::INDEX_W-1:0];
                res_next.byte_offset   = prod_ext[fbfl_pkg::OFFSET_W-1:0];
                res_next.in_use        = count_inc;
                state_next             = fbfl_pkg::ST_IDLE;
            end

            fbfl_pkg::ST_SWEEP:
            begin
                if (sweep_idx_reg == sweep_lim_reg)
                begin
                    // Chain is built; an empty pool leaves the head at the end mark.
                    head_next   = (sweep_lim_reg == '0) ? LINK_END : '0;
                    count_next  = '0;
                    state_next  = fbfl_pkg::ST_IDLE;
                    report_next = 1'b0;
                    if (report_reg)
                    begin
                        res_next.done          = 1'b1;
                        res_next.ok            = 1'b1;
                        res_next.granted_index = '0;
                        res_next.byte_offset   = '0;
                        res_next.in_use        = '0;
                    end
                end
                else
                begin
                    // Link one bucket to the next; the last one gets the end mark.
                    mem_wr_en      = 1'b1;
                    mem_wr_data    = (sweep_idx_inc == sweep_lim_reg) ? LINK_END : sweep_idx_inc;
                    sweep_idx_next = sweep_idx_inc;
                end
            end

            default:
            begin
                state_next = fbfl_pkg::ST_IDLE;
            end
        endcase
    end

    // Reset starts the relinking pass over the reset bucket count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbfl_pkg::ST_SWEEP;
            head_reg      <= LINK_END;
            count_reg     <= '0;
            sweep_idx_reg <= '0;
            sweep_lim_reg <= RESET_LIMIT;
            report_reg    <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            sweep_idx_reg <= sweep_idx_next;
            sweep_lim_reg <= sweep_lim_next;
            report_reg    <= report_next;
            res_reg       <= res_next;
        end
    end

    assign result = res_reg;

endmodule

// ----- hdl/fixed_block_free_list_allocator_unit.sv -----
// Channel   Direction  Handshake               Payload
// command   in         start high, busy low    cmd, bucket_index
// result    out        done for one cycle      ok, granted_index, byte_offset, in_use
// config    in         APB write, pready = 1   paddr, pwdata, prdata
//
// Free and the unused command: result in the cycle after the accepting edge; next item
// may follow at once. Allocate: the link is read at the head, then ST_ALLOC answers;
// on an empty pool it answers in the cycle after the accepting edge, as free does.
// Clear: ST_SWEEP writes one link per bucket of the effective count, then answers.
// After reset the same relinking pass runs over min(256, MAX_BUCKETS) buckets with busy
// high; configuration writes are taken meanwhile. The result side cannot stall.
module fixed_block_free_list_allocator_unit #(
    parameter int MAX_BUCKETS = fbfl_pkg::MAX_BUCKETS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fbfl_pkg::CMD_W-1:0]    cmd,
    input  logic [fbfl_pkg::INDEX_W-1:0]  bucket_index,
    output logic                          done,
    output logic                          ok,
    output logic [fbfl_pkg::INDEX_W-1:0]  granted_index,
    output logic [fbfl_pkg::OFFSET_W-1:0] byte_offset,
    output logic [fbfl_pkg::COUNT_W-1:0]  in_use,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbfl_pkg::ADDR_W-1:0]   paddr,
    input  logic [fbfl_pkg::DATA_W-1:0]   pwdata,
    output logic [fbfl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IDX_W  = $clog2(MAX_BUCKETS);
    localparam int LINK_W = $clog2(MAX_BUCKETS + 1);

    fbfl_pkg::cfg_t    cfg;
    fbfl_pkg::result_t result;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [LINK_W-1:0] mem_wr_data;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [LINK_W-1:0] mem_rd_data;

    // Configuration registers.
    fbfl_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Command sequencer: head, count, relinking pass.
    fbfl_ctrl #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .IDX_W       (IDX_W),
        .LINK_W      (LINK_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .bucket_index (bucket_index),
        .cfg          (cfg),
        .result       (result),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    // Next-free link per bucket.
    fbfl_link_mem #(
        .DEPTH  (MAX_BUCKETS),
        .ADDR_W (IDX_W),
        .DATA_W (LINK_W)
    ) u_link_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign done          = result.done;
    assign ok            = result.ok;
    assign granted_index = result.granted_index;
    assign byte_offset   = result.byte_offset;
    assign in_use        = result.in_use;

endmodule

// ----- hdl/fbfl_checker.sv -----
`include "fixed_block_free_list_allocator_unit_defines.svh"

module fbfl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [fbfl_pkg::CMD_W-1:0]    cmd,
    input logic                          done,
    input logic                          ok,
    input logic [fbfl_pkg::INDEX_W-1:0]  granted_index,
    input logic [fbfl_pkg::OFFSET_W-1:0] byte_offset
);

    logic accept;

    assign accept = start && !busy;

    // A result always leaves the block ready for the next item.
    `FBFL_ASSERT_IMPLY(a_done_not_busy, done, !busy)

    // A failed command carries no bucket.
    `FBFL_ASSERT_IMPLY(a_fail_no_grant, done && !ok, (granted_index == '0) && (byte_offset == '0))

    // Free writes the head in the accepting cycle and answers in the next.
    `FBFL_ASSERT_NEXT(a_free_one_cycle, accept && (cmd == fbfl_pkg::CMD_FREE), done && !busy)

    // Allocate either answers at once (empty pool) or waits on the link read.
    `FBFL_ASSERT_NEXT(a_alloc_progress, accept && (cmd == fbfl_pkg::CMD_ALLOC), done || busy)

    // Clear always runs the relinking pass before it answers.
    `FBFL_ASSERT_NEXT(a_clear_sweeps, accept && (cmd == fbfl_pkg::CMD_CLEAR), busy && !done)

endmodule

bind fixed_block_free_list_allocator_unit fbfl_checker u_fbfl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .done          (done),
    .ok            (ok),
    .granted_index (granted_index),
    .byte_offset   (byte_offset)
);

// ----- sim/pool_alloc_checker.sv -----
`timescale 1ns / 100ps

module pool_alloc_checker
    import fbfl_pkg::*;
#(
    parameter int POOL_DEPTH = MAX_BUCKETS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [INDEX_W-1:0]  bucket_index,
    input  logic                done,
    input  logic                ok,
    input  logic [INDEX_W-1:0]  granted_index,
    input  logic [OFFSET_W-1:0] byte_offset,
    input  logic [COUNT_W-1:0]  in_use,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                pready,
    output int                  fail_count,
    output int                  outstanding
);

    // End-of-list mark in the link memory.
    localparam logic [COUNT_W-1:0] LIST_END = COUNT_W'(POOL_DEPTH);

    // Shadow copy of the pool: link memory, list head, in-use count and registers.
    logic [COUNT_W-1:0] link_mem [POOL_DEPTH];
    logic [COUNT_W-1:0] head_ptr;
    logic [COUNT_W-1:0] used_cnt;
    logic [COUNT_W-1:0] cfg_count;
    logic [BYTES_W-1:0] cfg_bytes;

    // Results still owed by the block, oldest first.
    result_t awaited_results [$];
    int      mismatches;

    // The register value clamped to the pool depth.
    function automatic int unsigned usable_buckets();
        return (cfg_count > POOL_DEPTH) ? POOL_DEPTH : cfg_count;
    endfunction

    // Chain buckets 0 .. count-1 in order and empty the pool.
    function automatic void relink_pool();
        int unsigned n;
        n = usable_buckets();
        for (int unsigned i = 0; i + 1 < n; i++)
            link_mem[i] = COUNT_W'(i + 1);
        if (n > 0)
        begin
            link_mem[n - 1] = LIST_END;
            head_ptr = '0;
        end
        else
        begin
            head_ptr = LIST_END;
        end
        used_cnt = '0;
    endfunction

    // Apply one command to the shadow pool and return the result it must produce.
    function automatic result_t apply_pool_cmd(logic [CMD_W-1:0] op, logic [INDEX_W-1:0] idx);
        result_t     r;
        int unsigned grant;
        r = '0;
        r.done = 1'b1;
        case (op)
            CMD_ALLOC:
            begin
                if (head_ptr < POOL_DEPTH)
                begin
                    grant = head_ptr;
                    head_ptr = link_mem[grant];
                    if (used_cnt < COUNT_MAX)
                        used_cnt = used_cnt + 1'b1;
                    r.ok = 1'b1;
                    r.granted_index = INDEX_W'(grant);
                    r.byte_offset = OFFSET_W'(grant * cfg_bytes);
                end
            end
            CMD_FREE:
            begin
                // No double-free check: the bucket is simply pushed again.
                if (idx < usable_buckets())
                begin
                    link_mem[idx] = head_ptr;
                    head_ptr = COUNT_W'(idx);
                    if (used_cnt > 0)
                        used_cnt = used_cnt - 1'b1;
                    r.ok = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                relink_pool();
                r.ok = 1'b1;
            end
            default:
            begin
                // The spare code changes nothing and reports failure.
            end
        endcase
        r.in_use = used_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Track register writes, compare each result, and predict each accepted item.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            cfg_count = BUCKET_COUNT_RST;
            cfg_bytes = BUCKET_BYTES_RST;
            for (int i = 0; i < POOL_DEPTH; i++)
                link_mem[i] = LIST_END;
            relink_pool();
            awaited_results.delete();
            mismatches = 0;
            outstanding <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_SEL_COUNT)
                    cfg_count = pwdata[COUNT_W-1:0];
                else
                    cfg_bytes = pwdata[BYTES_W-1:0];
            end

            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with no item outstanding: ok %0d, index %0d, in_use %0d",
                           ok, granted_index, in_use);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("ok", want.ok, ok);
                    check_field("granted_index", want.granted_index, granted_index);
                    check_field("byte_offset", want.byte_offset, byte_offset);
                    check_field("in_use", want.in_use, in_use);
                end
            end

            if (start && !busy)
                awaited_results.push_back(apply_pool_cmd(cmd, bucket_index));

            outstanding <= awaited_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import fbfl_pkg::*;

    // Code 3 is not a command; the block must answer it with ok low.
    localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_COUNT  = {REG_SEL_COUNT, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_BYTES  = {REG_SEL_BYTES, 2'b00};
    localparam int                POOL_DEPTH  = MAX_BUCKETS_DEF;
    localparam int                STALL_LIMIT = 5000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    cmd;
    logic [INDEX_W-1:0]  bucket_index;
    logic                done;
    logic                ok;
    logic [INDEX_W-1:0]  granted_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  in_use;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int          fail_count;
    int          outstanding;
    int          stall_cycles;
    int unsigned pool_size;

    fixed_block_free_list_allocator_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .bucket_index  (bucket_index),
        .done          (done),
        .ok            (ok),
        .granted_index (granted_index),
        .byte_offset   (byte_offset),
        .in_use        (in_use),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pool_alloc_checker #(
        .POOL_DEPTH (POOL_DEPTH)
    ) alloc_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .bucket_index  (bucket_index),
        .done          (done),
        .ok            (ok),
        .granted_index (granted_index),
        .byte_offset   (byte_offset),
        .in_use        (in_use),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: end the run if nothing moves on any port for too long.
    initial
    begin
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (psel && penable && pwrite))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Free indices below this value are accepted by the block.
    function automatic int unsigned usable_buckets();
        return (pool_size > POOL_DEPTH) ? POOL_DEPTH : pool_size;
    endfunction

    function automatic int unsigned pick_count();
        int unsigned roll;
        roll = $urandom_range(9);
        case (roll)
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 256;
            4:       return 511;
            5:       return $urandom_range(510, 257);
            6:       return $urandom_range(255, 17);
            default: return $urandom_range(16, 1);
        endcase
    endfunction

    function automatic int unsigned pick_bytes();
        int unsigned roll;
        roll = $urandom_range(4);
        case (roll)
            0:       return 1;
            1:       return 65535;
            2:       return $urandom_range(255, 1);
            default: return $urandom_range(65534, 2);
        endcase
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [INDEX_W-1:0] idx);
        start <= 1'b1;
        cmd <= op;
        bucket_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_COUNT)
            pool_size = data[COUNT_W-1:0];
    endtask

    // Hold off new items until every result is back and the block is idle.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random traffic: mostly allocate and in-range free, some noise.
    task automatic run_phase(input int n_items, input bit with_gaps);
        int unsigned alloc_pct;
        int unsigned roll;
        alloc_pct = $urandom_range(70, 30);
        for (int k = 0; k < n_items; k++)
        begin
            if (with_gaps && $urandom_range(99) < 20)
            begin
                start <= 1'b0;
                repeat ($urandom_range(15, 1)) @(posedge clk);
            end
            roll = $urandom_range(99);
            if (roll < 2)
                send_item(CMD_CLEAR, INDEX_W'($urandom));
            else if (roll < 4)
                send_item(CMD_UNUSED, INDEX_W'($urandom));
            else if (roll < 9)
                send_item(CMD_FREE, INDEX_W'($urandom));
            else if (roll < 9 + alloc_pct)
                send_item(CMD_ALLOC, INDEX_W'($urandom));
            else if (usable_buckets() == 0)
                send_item(CMD_FREE, INDEX_W'($urandom));
            else
                send_item(CMD_FREE, INDEX_W'($urandom_range(usable_buckets() - 1)));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_ALLOC;
        bucket_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pool_size = BUCKET_COUNT_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Let the relinking pass after reset finish.
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);

        // Four buckets at the largest size: drain, refill, bad and repeated frees.
        write_reg(ADDR_COUNT, 4);
        write_reg(ADDR_BYTES, 65535);
        send_item(CMD_CLEAR, 8'h00);
        repeat (5) send_item(CMD_ALLOC, 8'hFF);
        send_item(CMD_FREE, 8'd3);
        send_item(CMD_FREE, 8'd4);
        send_item(CMD_FREE, 8'hFF);
        send_item(CMD_ALLOC, 8'h00);
        send_item(CMD_UNUSED, 8'hAA);
        send_item(CMD_FREE, 8'd0);
        send_item(CMD_FREE, 8'd0);
        send_item(CMD_FREE, 8'd1);
        send_item(CMD_FREE, 8'd2);
        send_item(CMD_FREE, 8'd3);
        send_item(CMD_FREE, 8'd0);
        send_item(CMD_ALLOC, 8'h55);
        send_item(CMD_ALLOC, 8'h00);

        // A count of zero leaves the pool empty after clear.
        settle();
        write_reg(ADDR_COUNT, 0);
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_ALLOC, 8'h00);
        send_item(CMD_FREE, 8'd0);

        // An oversized count is clamped to the pool depth; smallest bucket size.
        settle();
        write_reg(ADDR_COUNT, 511);
        write_reg(ADDR_BYTES, 1);
        send_item(CMD_ALLOC, 8'h00);
        send_item(CMD_CLEAR, 8'hFF);
        send_item(CMD_FREE, 8'd255);
        send_item(CMD_ALLOC, 8'h00);

        // Random phases under changing settings, some without a clear first.
        for (int p = 0; p < 10; p++)
        begin
            settle();
            write_reg(ADDR_COUNT, pick_count());
            write_reg(ADDR_BYTES, pick_bytes());
            if ($urandom_range(9) < 7)
                send_item(CMD_CLEAR, INDEX_W'($urandom));
            run_phase(25, $urandom_range(3) != 0);
            if (p == 3)
                settle();
            run_phase(25, $urandom_range(3) != 0);
        end

        // Closing phase at full rate.
        settle();
        write_reg(ADDR_COUNT, pick_count());
        write_reg(ADDR_BYTES, pick_bytes());
        send_item(CMD_CLEAR, 8'h00);
        run_phase(40, 1'b0);

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
